@@ rtl/counting_semaphore_table_unit_defines.svh @@
// Assertion macros for the counting semaphore table unit.
`ifndef COUNTING_SEMAPHORE_TABLE_UNIT_DEFINES_SVH
`define COUNTING_SEMAPHORE_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define CSTU_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("Same-cycle implication failed.");
`define CSTU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("Next-cycle implication failed.");
`else
`define CSTU_ASSERT_SAME(label, ante, cons)
`define CSTU_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/cstu_pkg.sv @@
// Package with codes, widths and types for the counting semaphore table unit.
package cstu_pkg;

	localparam int SEMAPHORES_DEFAULT = 16;
	localparam int TASKS_DEFAULT = 16;

	localparam int CMD_W = 3;
	localparam int ID_W = 5;
	localparam int CNT_W = 16;
	localparam int TASK_W = 4;
	localparam int STATUS_W = 4;

	localparam logic [CMD_W-1:0] CMD_CREATE_FREE = 3'd0;
	localparam logic [CMD_W-1:0] CMD_CREATE_AT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SIGNAL = 3'd3;
	localparam logic [CMD_W-1:0] CMD_WAIT = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK = 4'd0;
	localparam logic [STATUS_W-1:0] ST_PAR = 4'd1;
	localparam logic [STATUS_W-1:0] ST_NOID = 4'd2;
	localparam logic [STATUS_W-1:0] ST_ID = 4'd3;
	localparam logic [STATUS_W-1:0] ST_OBJ = 4'd4;
	localparam logic [STATUS_W-1:0] ST_NOEXS = 4'd5;
	localparam logic [STATUS_W-1:0] ST_QOVR = 4'd6;
	localparam logic [STATUS_W-1:0] ST_BLOCKED = 4'd7;
	localparam logic [STATUS_W-1:0] ST_QFULL = 4'd8;
	localparam logic [STATUS_W-1:0] ST_DLT = 4'd9;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_POP,
		S_DEL,
		S_DEL_END
	} cstu_state_t;

endpackage

@@ rtl/counting_semaphore_table_unit.sv @@
// Counting semaphore table: command sequencer around a record RAM and a waiter RAM.
// Create, bad-ID, bad-parameter, missing-semaphore: result in the cycle after accept, busy low.
// Signal and wait: result registered out of S_READ, or out of S_POP when signal wakes a waiter; busy
// holds the next transaction off until the edge that ends the last result of the command.
// Delete with n waiters: n + 1 results, one per cycle, the first out of S_READ when n is 0
// and out of S_DEL otherwise. Reset clears the allocation map; no RAM clearing.
`include "counting_semaphore_table_unit_defines.svh"

module counting_semaphore_table_unit
	import cstu_pkg::*;
#(
	parameter int SEMAPHORES = SEMAPHORES_DEFAULT,
	parameter int TASKS = TASKS_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [CMD_W-1:0]    command,
	input  logic [ID_W-1:0]     sem_id,
	input  logic [CNT_W-1:0]    initial_count,
	input  logic [CNT_W-1:0]    max_count,
	input  logic [TASK_W-1:0]   task_id,
	output logic                result_valid,
	output logic [STATUS_W-1:0] status,
	output logic [ID_W-1:0]     result_id,
	output logic                woken_valid,
	output logic [TASK_W-1:0]   woken_task,
	output logic                last
);

	localparam int SW = (SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1;
	localparam int QW = $clog2(TASKS);
	localparam int OW = $clog2(TASKS + 1);
	localparam int WDEPTH = SEMAPHORES * TASKS;
	localparam int WAW = $clog2(WDEPTH);
	localparam int REC_W = 2 * CNT_W + QW + OW;

	function automatic logic [QW-1:0] q_inc(input logic [QW-1:0] h);
		return (int'(h) == TASKS - 1) ? '0 : QW'(int'(h) + 1);
	endfunction

	function automatic logic [QW-1:0] q_tail(input logic [QW-1:0] h, input logic [OW-1:0] o);
		int sum;
		sum = int'(h) + int'(o);
		if (sum >= TASKS) begin
			sum = sum - TASKS;
		end
		return QW'(sum);
	endfunction

	function automatic logic [WAW-1:0] w_addr(input logic [SW-1:0] s, input logic [QW-1:0] q);
		return WAW'(int'(s) * TASKS + int'(q));
	endfunction

	cstu_state_t state_q, state_d;

	logic [SEMAPHORES-1:0] in_use_q;
	logic [CMD_W-1:0] cmd_q;
	logic [ID_W-1:0] id_q;
	logic [SW-1:0] s_q;
	logic [TASK_W-1:0] task_q;
	logic [QW-1:0] head_q, head_d;
	logic [OW-1:0] occ_q, occ_d;

	logic result_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [ID_W-1:0] result_id_q;
	logic woken_valid_q;
	logic [TASK_W-1:0] woken_task_q;
	logic last_q;

	logic emit;
	logic [STATUS_W-1:0] o_status;
	logic [ID_W-1:0] o_id;
	logic o_wv;
	logic [TASK_W-1:0] o_wt;
	logic o_last;

	logic rec_we, rec_re;
	logic [SW-1:0] rec_waddr, rec_raddr;
	logic [REC_W-1:0] rec_wdata, rec_rdata;
	logic [CNT_W-1:0] cnt_r, max_r;
	logic [QW-1:0] head_r;
	logic [OW-1:0] occ_r;

	logic w_we, w_re;
	logic [WAW-1:0] w_waddr, w_raddr;
	logic [TASK_W-1:0] w_rdata;

	logic map_set, map_clr;
	logic [SW-1:0] map_idx;

	logic accept;
	logic id_ok, bad_par, free_found;
	logic [SW-1:0] in_s, free_idx;

	assign accept = start && (state_q == S_IDLE);
	assign busy = (state_q != S_IDLE);
	assign id_ok = (sem_id != '0) && (int'(sem_id) <= SEMAPHORES);
	assign in_s = id_ok ? SW'(sem_id - 5'd1) : '0;
	assign bad_par = (max_count == '0) || (max_count < initial_count);
	assign {cnt_r, max_r, head_r, occ_r} = rec_rdata;

	always_comb begin
		free_found = 1'b0;
		free_idx = '0;
		for (int i = SEMAPHORES - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_found = 1'b1;
				free_idx = SW'(i);
			end
		end
	end

	cstu_ram #(.WIDTH(REC_W), .DEPTH(SEMAPHORES)) u_rec_ram (
		.clk(clk),
		.we(rec_we),
		.waddr(rec_waddr),
		.wdata(rec_wdata),
		.re(rec_re),
		.raddr(rec_raddr),
		.rdata(rec_rdata)
	);

	cstu_ram #(.WIDTH(TASK_W), .DEPTH(WDEPTH)) u_waiter_ram (
		.clk(clk),
		.we(w_we),
		.waddr(w_waddr),
		.wdata(task_q),
		.re(w_re),
		.raddr(w_raddr),
		.rdata(w_rdata)
	);

	always_comb begin
		state_d = state_q;
		emit = 1'b0;
		o_status = ST_OK;
		o_id = id_q;
		o_wv = 1'b0;
		o_wt = '0;
		o_last = 1'b1;
		rec_we = 1'b0;
		rec_waddr = s_q;
		rec_wdata = {cnt_r, max_r, head_r, occ_r};
		rec_re = 1'b0;
		rec_raddr = in_s;
		w_we = 1'b0;
		w_waddr = w_addr(s_q, q_tail(head_r, occ_r));
		w_re = 1'b0;
		w_raddr = w_addr(s_q, head_r);
		map_set = 1'b0;
		map_clr = 1'b0;
		map_idx = s_q;
		head_d = head_q;
		occ_d = occ_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					emit = 1'b1;
					o_id = '0;
					case (command)
						CMD_CREATE_FREE: begin
							if (bad_par) begin
								o_status = ST_PAR;
							end else if (!free_found) begin
								o_status = ST_NOID;
							end else begin
								rec_we = 1'b1;
								rec_waddr = free_idx;
								rec_wdata = {initial_count, max_count, {QW{1'b0}}, {OW{1'b0}}};
								map_set = 1'b1;
								map_idx = free_idx;
								o_id = ID_W'(int'(free_idx) + 1);
							end
						end
						CMD_CREATE_AT: begin
							if (!id_ok) begin
								o_status = ST_ID;
							end else begin
								o_id = sem_id;
								if (bad_par) begin
									o_status = ST_PAR;
								end else if (in_use_q[in_s]) begin
									o_status = ST_OBJ;
								end else begin
									rec_we = 1'b1;
									rec_waddr = in_s;
									rec_wdata = {initial_count, max_count, {QW{1'b0}}, {OW{1'b0}}};
									map_set = 1'b1;
									map_idx = in_s;
								end
							end
						end
						CMD_DELETE, CMD_SIGNAL, CMD_WAIT: begin
							if (!id_ok) begin
								o_status = ST_ID;
							end else if (!in_use_q[in_s]) begin
								o_status = ST_NOEXS;
								o_id = sem_id;
							end else begin
								emit = 1'b0;
								rec_re = 1'b1;
								state_d = S_READ;
							end
						end
						default: begin
							o_status = ST_PAR;
						end
					endcase
				end
			end
			S_READ: begin
				state_d = S_IDLE;
				case (cmd_q)
					CMD_SIGNAL: begin
						if (cnt_r == max_r) begin
							emit = 1'b1;
							o_status = ST_QOVR;
						end else if (occ_r != '0) begin
							w_re = 1'b1;
							rec_we = 1'b1;
							rec_wdata = {cnt_r, max_r, q_inc(head_r), occ_r - 1'b1};
							state_d = S_POP;
						end else begin
							emit = 1'b1;
							rec_we = 1'b1;
							rec_wdata = {cnt_r + 16'd1, max_r, head_r, occ_r};
						end
					end
					CMD_WAIT: begin
						emit = 1'b1;
						if (cnt_r != '0) begin
							rec_we = 1'b1;
							rec_wdata = {cnt_r - 16'd1, max_r, head_r, occ_r};
						end else if (int'(occ_r) >= TASKS) begin
							o_status = ST_QFULL;
						end else begin
							w_we = 1'b1;
							rec_we = 1'b1;
							rec_wdata = {cnt_r, max_r, head_r, occ_r + 1'b1};
							o_status = ST_BLOCKED;
						end
					end
					CMD_DELETE: begin
						if (occ_r == '0) begin
							emit = 1'b1;
							map_clr = 1'b1;
						end else begin
							w_re = 1'b1;
							head_d = q_inc(head_r);
							occ_d = occ_r - 1'b1;
							state_d = S_DEL;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_POP: begin
				emit = 1'b1;
				o_wv = 1'b1;
				o_wt = w_rdata;
				state_d = S_IDLE;
			end
			S_DEL: begin
				emit = 1'b1;
				o_status = ST_DLT;
				o_wv = 1'b1;
				o_wt = w_rdata;
				o_last = 1'b0;
				if (occ_q != '0) begin
					w_re = 1'b1;
					w_raddr = w_addr(s_q, head_q);
					head_d = q_inc(head_q);
					occ_d = occ_q - 1'b1;
				end else begin
					state_d = S_DEL_END;
				end
			end
			S_DEL_END: begin
				emit = 1'b1;
				map_clr = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= emit;
			if (map_set) begin
				in_use_q[map_idx] <= 1'b1;
			end else if (map_clr) begin
				in_use_q[map_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= command;
			id_q <= sem_id;
			s_q <= in_s;
			task_q <= task_id;
		end
		head_q <= head_d;
		occ_q <= occ_d;
		status_q <= o_status;
		result_id_q <= o_id;
		woken_valid_q <= o_wv;
		woken_task_q <= o_wt;
		last_q <= o_last;
	end

	assign result_valid = result_valid_q;
	assign status = status_q;
	assign result_id = result_id_q;
	assign woken_valid = woken_valid_q;
	assign woken_task = woken_task_q;
	assign last = last_q;

	// A delete reports its waiters back to back and always ends with a final result.
	`CSTU_ASSERT_NEXT(a_del_stream_continues, result_valid && !last, result_valid)
	`CSTU_ASSERT_SAME(a_non_last_is_release, result_valid && !last,
		woken_valid && (status == ST_DLT))
	`CSTU_ASSERT_NEXT(a_accept_no_early_release, start && !busy, !result_valid || last)

endmodule

@@ rtl/cstu_ram.sv @@
// Generic single-port-write, registered-read RAM.
module cstu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ verif/counting_semaphore_table_unit_checker.sv @@
`timescale 1ns / 100ps
// Checker that predicts and compares the result transactions of the semaphore table unit.
module counting_semaphore_table_unit_checker
	import cstu_pkg::*;
#(
	parameter int SEMAPHORES = SEMAPHORES_DEFAULT,
	parameter int TASKS = TASKS_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  logic [CMD_W-1:0]    command,
	input  logic [ID_W-1:0]     sem_id,
	input  logic [CNT_W-1:0]    initial_count,
	input  logic [CNT_W-1:0]    max_count,
	input  logic [TASK_W-1:0]   task_id,
	input  logic                result_valid,
	input  logic [STATUS_W-1:0] status,
	input  logic [ID_W-1:0]     result_id,
	input  logic                woken_valid,
	input  logic [TASK_W-1:0]   woken_task,
	input  logic                last,
	output int                  mismatch_count,
	output int                  replies_pending,
	output int                  replies_checked,
	output bit [15:0]           status_seen
);

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     result_id;
		logic                woken_valid;
		logic [TASK_W-1:0]   woken_task;
		logic                last;
	} sem_reply_t;

	sem_reply_t replies_due[$];
	bit in_use[SEMAPHORES];
	logic [CNT_W-1:0] sem_level[SEMAPHORES];
	logic [CNT_W-1:0] sem_ceiling[SEMAPHORES];
	int wait_head[SEMAPHORES];
	int wait_depth[SEMAPHORES];
	logic [TASK_W-1:0] waiting_tasks[SEMAPHORES][TASKS];

	function automatic void owe_reply(input logic [STATUS_W-1:0] st, input int id,
		input logic wv, input logic [TASK_W-1:0] wt, input logic lst);
		sem_reply_t r;
		r.status = st;
		r.result_id = ID_W'(id);
		r.woken_valid = wv;
		r.woken_task = wt;
		r.last = lst;
		replies_due.push_back(r);
	endfunction

	function automatic logic [TASK_W-1:0] dequeue_waiter(input int s);
		logic [TASK_W-1:0] t;
		t = waiting_tasks[s][wait_head[s]];
		wait_head[s] = (wait_head[s] + 1) % TASKS;
		wait_depth[s]--;
		return t;
	endfunction

	function automatic void open_semaphore(input int s, input logic [CNT_W-1:0] ini,
		input logic [CNT_W-1:0] mx);
		sem_level[s] = ini;
		sem_ceiling[s] = mx;
		wait_head[s] = 0;
		wait_depth[s] = 0;
		in_use[s] = 1'b1;
	endfunction

	function automatic void apply_command(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
		input logic [CNT_W-1:0] ini, input logic [CNT_W-1:0] mx, input logic [TASK_W-1:0] tsk);
		bit bad_par;
		bit id_ok;
		bit placed;
		int s;
		bad_par = (mx == '0) || (mx < ini);
		id_ok = (id >= 1) && (id <= SEMAPHORES);
		s = id_ok ? int'(id) - 1 : 0;
		if (cmd == CMD_CREATE_FREE) begin
			if (bad_par) begin
				owe_reply(ST_PAR, 0, 1'b0, '0, 1'b1);
			end else begin
				placed = 1'b0;
				for (int i = 0; i < SEMAPHORES; i++) begin
					if (!placed && !in_use[i]) begin
						open_semaphore(i, ini, mx);
						owe_reply(ST_OK, i + 1, 1'b0, '0, 1'b1);
						placed = 1'b1;
					end
				end
				if (!placed)
					owe_reply(ST_NOID, 0, 1'b0, '0, 1'b1);
			end
		end else if (cmd > CMD_WAIT) begin
			owe_reply(ST_PAR, 0, 1'b0, '0, 1'b1);
		end else if (!id_ok) begin
			owe_reply(ST_ID, 0, 1'b0, '0, 1'b1);
		end else if (cmd == CMD_CREATE_AT) begin
			if (bad_par) begin
				owe_reply(ST_PAR, id, 1'b0, '0, 1'b1);
			end else if (in_use[s]) begin
				owe_reply(ST_OBJ, id, 1'b0, '0, 1'b1);
			end else begin
				open_semaphore(s, ini, mx);
				owe_reply(ST_OK, id, 1'b0, '0, 1'b1);
			end
		end else if (!in_use[s]) begin
			owe_reply(ST_NOEXS, id, 1'b0, '0, 1'b1);
		end else begin
			case (cmd)
				CMD_DELETE: begin
					while (wait_depth[s] != 0)
						owe_reply(ST_DLT, id, 1'b1, dequeue_waiter(s), 1'b0);
					wait_head[s] = 0;
					in_use[s] = 1'b0;
					owe_reply(ST_OK, id, 1'b0, '0, 1'b1);
				end
				CMD_SIGNAL: begin
					if (sem_level[s] == sem_ceiling[s]) begin
						owe_reply(ST_QOVR, id, 1'b0, '0, 1'b1);
					end else if (wait_depth[s] != 0) begin
						owe_reply(ST_OK, id, 1'b1, dequeue_waiter(s), 1'b1);
					end else begin
						sem_level[s] = sem_level[s] + 1'b1;
						owe_reply(ST_OK, id, 1'b0, '0, 1'b1);
					end
				end
				default: begin
					if (sem_level[s] != '0) begin
						sem_level[s] = sem_level[s] - 1'b1;
						owe_reply(ST_OK, id, 1'b0, '0, 1'b1);
					end else if (wait_depth[s] >= TASKS) begin
						owe_reply(ST_QFULL, id, 1'b0, '0, 1'b1);
					end else begin
						waiting_tasks[s][(wait_head[s] + wait_depth[s]) % TASKS] = tsk;
						wait_depth[s]++;
						owe_reply(ST_BLOCKED, id, 1'b0, '0, 1'b1);
					end
				end
			endcase
		end
	endfunction

	function automatic int check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sem_reply_t want;
		int bad;
		if (!arst_n) begin
			replies_due.delete();
			for (int i = 0; i < SEMAPHORES; i++) begin
				in_use[i] = 1'b0;
				wait_head[i] = 0;
				wait_depth[i] = 0;
			end
			mismatch_count = 0;
			replies_checked = 0;
			status_seen = '0;
		end else begin
			if (result_valid) begin
				replies_checked++;
				status_seen[status] = 1'b1;
				if (replies_due.size() == 0) begin
					$error("result transaction with no command outstanding: status %0d, result_id %0d",
						status, result_id);
					mismatch_count++;
				end else begin
					want = replies_due.pop_front();
					bad = 0;
					bad += check_field("status", want.status, status);
					bad += check_field("result_id", want.result_id, result_id);
					bad += check_field("woken_valid", want.woken_valid, woken_valid);
					bad += check_field("woken_task", want.woken_task, woken_task);
					bad += check_field("last", want.last, last);
					mismatch_count += bad;
				end
			end
			if (start && !busy)
				apply_command(command, sem_id, initial_count, max_count, task_id);
		end
		replies_pending = replies_due.size();
	end

endmodule

@@ verif/counting_semaphore_table_unit_tb.sv @@
`timescale 1ns / 100ps
// Testbench top: drives semaphore commands into the table unit and reports the verdict.
module counting_semaphore_table_unit_tb;
	import cstu_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_ITEMS = 150;
	localparam logic [CMD_W-1:0] CMD_BAD_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_BAD_LAST = 3'd7;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [CMD_W-1:0]    command;
	logic [ID_W-1:0]     sem_id;
	logic [CNT_W-1:0]    initial_count;
	logic [CNT_W-1:0]    max_count;
	logic [TASK_W-1:0]   task_id;
	logic                result_valid;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0]     result_id;
	logic                woken_valid;
	logic [TASK_W-1:0]   woken_task;
	logic                last;

	int mismatch_count;
	int replies_pending;
	int replies_checked;
	bit [15:0] status_seen;

	int idle_pct;
	int idle_plan[3] = '{0, 69, 18};
	int items_sent;
	int directed_sent;
	int quiet_cycles;
	bit alive[SEMAPHORES_DEFAULT];

	counting_semaphore_table_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.sem_id(sem_id),
		.initial_count(initial_count),
		.max_count(max_count),
		.task_id(task_id),
		.result_valid(result_valid),
		.status(status),
		.result_id(result_id),
		.woken_valid(woken_valid),
		.woken_task(woken_task),
		.last(last)
	);

	counting_semaphore_table_unit_checker reply_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.sem_id(sem_id),
		.initial_count(initial_count),
		.max_count(max_count),
		.task_id(task_id),
		.result_valid(result_valid),
		.status(status),
		.result_id(result_id),
		.woken_valid(woken_valid),
		.woken_task(woken_task),
		.last(last),
		.mismatch_count(mismatch_count),
		.replies_pending(replies_pending),
		.replies_checked(replies_checked),
		.status_seen(status_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [CNT_W-1:0] any_count();
		return CNT_W'($urandom);
	endfunction

	function automatic logic [TASK_W-1:0] any_task();
		return TASK_W'($urandom);
	endfunction

	function automatic logic [ID_W-1:0] pick_id();
		return ($urandom_range(3) == 0) ? ID_W'($urandom_range(1, SEMAPHORES_DEFAULT))
			: ID_W'($urandom_range(1, 4));
	endfunction

	task automatic issue(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
		input logic [CNT_W-1:0] ini, input logic [CNT_W-1:0] mx, input logic [TASK_W-1:0] tsk);
		bit params_ok;
		bit id_ok;
		params_ok = (mx != '0) && (mx >= ini);
		id_ok = (id >= 1) && (id <= SEMAPHORES_DEFAULT);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		sem_id <= id;
		initial_count <= ini;
		max_count <= mx;
		task_id <= tsk;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
		if (cmd == CMD_CREATE_FREE && params_ok) begin
			for (int i = 0; i < SEMAPHORES_DEFAULT; i++) begin
				if (!alive[i]) begin
					alive[i] = 1'b1;
					break;
				end
			end
		end else if (cmd == CMD_CREATE_AT && params_ok && id_ok) begin
			alive[id - 1] = 1'b1;
		end else if (cmd == CMD_DELETE && id_ok) begin
			alive[id - 1] = 1'b0;
		end
	endtask

	task automatic exercise_semaphore();
		logic [ID_W-1:0] id;
		logic [CNT_W-1:0] mx;
		id = pick_id();
		if (!alive[id - 1]) begin
			mx = CNT_W'($urandom_range(1, 4));
			issue(CMD_CREATE_AT, id, CNT_W'($urandom_range(0, mx)), mx, any_task());
		end
		repeat ($urandom_range(3, 10))
			issue($urandom_range(1) ? CMD_SIGNAL : CMD_WAIT, id, any_count(), any_count(),
				any_task());
		if ($urandom_range(2) == 0)
			issue(CMD_DELETE, id, any_count(), any_count(), any_task());
	endtask

	task automatic pile_waiters(input bit to_limit);
		logic [ID_W-1:0] id;
		int n;
		id = pick_id();
		if (alive[id - 1])
			issue(CMD_DELETE, id, any_count(), any_count(), any_task());
		issue(CMD_CREATE_AT, id, '0, CNT_W'($urandom_range(1, 65535)), any_task());
		n = (to_limit || $urandom_range(1) != 0) ? TASKS_DEFAULT + 1 : $urandom_range(1, 8);
		repeat (n)
			issue(CMD_WAIT, id, any_count(), any_count(), any_task());
		if (to_limit || $urandom_range(1) != 0)
			issue(CMD_DELETE, id, any_count(), any_count(), any_task());
		else
			repeat ($urandom_range(1, n))
				issue(CMD_SIGNAL, id, any_count(), any_count(), any_task());
	endtask

	task automatic fill_table();
		logic [CNT_W-1:0] mx;
		repeat (SEMAPHORES_DEFAULT + 1) begin
			mx = CNT_W'($urandom_range(1, 65535));
			issue(CMD_CREATE_FREE, ID_W'($urandom), CNT_W'($urandom_range(0, mx)), mx, any_task());
		end
		for (int i = 1; i <= SEMAPHORES_DEFAULT; i++)
			issue(CMD_DELETE, ID_W'(i), any_count(), any_count(), any_task());
	endtask

	task automatic wide_create();
		logic [ID_W-1:0] id;
		logic [CNT_W-1:0] mx;
		id = pick_id();
		mx = CNT_W'($urandom_range(1, 65535));
		if (alive[id - 1])
			issue(CMD_DELETE, id, any_count(), any_count(), any_task());
		issue(CMD_CREATE_AT, id, $urandom_range(1) ? mx : mx - 1'b1, mx, any_task());
		repeat (2)
			issue(CMD_SIGNAL, id, any_count(), any_count(), any_task());
		issue(CMD_WAIT, id, any_count(), any_count(), any_task());
	endtask

	initial begin
		int pick;
		arst_n = 1'b0;
		start = 1'b0;
		command = CMD_CREATE_FREE;
		sem_id = '0;
		initial_count = '0;
		max_count = '0;
		task_id = '0;
		quiet_cycles = 0;
		items_sent = 0;
		idle_pct = 18;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(CMD_BAD_FIRST, 5'd31, 16'hFFFF, 16'hFFFF, 4'hF);
		issue(CMD_BAD_LAST, 5'd0, 16'h0000, 16'h0000, 4'h0);
		issue(CMD_CREATE_FREE, 5'd3, 16'd0, 16'd0, 4'h0);
		issue(CMD_CREATE_FREE, 5'd0, 16'd5, 16'd4, 4'h0);
		issue(CMD_CREATE_FREE, 5'd31, 16'd0, 16'd1, 4'h0);
		issue(CMD_CREATE_AT, 5'd0, 16'd0, 16'd1, 4'h0);
		issue(CMD_CREATE_AT, 5'd17, 16'd0, 16'd1, 4'h0);
		issue(CMD_CREATE_AT, 5'd31, 16'd0, 16'd0, 4'h0);
		issue(CMD_CREATE_AT, 5'd2, 16'd7, 16'd6, 4'h0);
		issue(CMD_CREATE_AT, 5'd1, 16'd0, 16'd1, 4'h0);
		issue(CMD_CREATE_AT, 5'd16, 16'hFFFF, 16'hFFFF, 4'h0);
		issue(CMD_SIGNAL, 5'd16, 16'd0, 16'd0, 4'h0);
		issue(CMD_WAIT, 5'd16, 16'd0, 16'd0, 4'h0);
		issue(CMD_SIGNAL, 5'd16, 16'd0, 16'd0, 4'h0);
		issue(CMD_DELETE, 5'd5, 16'd0, 16'd0, 4'h0);
		issue(CMD_WAIT, 5'd20, 16'd0, 16'd0, 4'h0);
		issue(CMD_WAIT, 5'd1, 16'd0, 16'd0, 4'hF);
		issue(CMD_WAIT, 5'd1, 16'd0, 16'd0, 4'h0);
		issue(CMD_SIGNAL, 5'd1, 16'd0, 16'd0, 4'h0);
		issue(CMD_WAIT, 5'd1, 16'd0, 16'd0, 4'hA);
		issue(CMD_DELETE, 5'd1, 16'd0, 16'd0, 4'h0);
		issue(CMD_DELETE, 5'd1, 16'd0, 16'd0, 4'h0);
		issue(CMD_CREATE_FREE, 5'd0, 16'd3, 16'd3, 4'h0);
		issue(CMD_DELETE, 5'd16, 16'd0, 16'd0, 4'h0);
		issue(CMD_DELETE, 5'd1, 16'd0, 16'd0, 4'h0);
		directed_sent = items_sent;

		// A full waiter queue and a full table are forced once before the random mix.
		idle_pct = idle_plan[0];
		pile_waiters(1'b1);
		idle_pct = idle_plan[1];
		fill_table();
		while (items_sent - directed_sent < RANDOM_ITEMS) begin
			idle_pct = idle_plan[((items_sent - directed_sent) / 30) % 3];
			pick = $urandom_range(99);
			if (pick < 40)
				exercise_semaphore();
			else if (pick < 55)
				pile_waiters(1'b0);
			else if (pick < 68)
				wide_create();
			else
				issue(CMD_W'($urandom_range(7)), ID_W'($urandom_range(31)), any_count(),
					any_count(), any_task());
		end
		start <= 1'b0;

		while (replies_pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
		$display("Sent %0d commands (%0d directed) and checked %0d result transactions.",
			items_sent, directed_sent, replies_checked);
		$display("The block returned %0d of the 10 status codes.", $countones(status_seen));
		if (mismatch_count == 0 && replies_pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
